/* rtl/periodic_sphere_overlap_test_unit_macros.svh */
// ----------------------------------------------------------------------------
// periodic sphere overlap test unit - assertion macros
// shared concurrent check forms, clocked on clock and held off during reset
// ----------------------------------------------------------------------------
`ifndef PERIODIC_SPHERE_OVERLAP_TEST_UNIT_MACROS_SVH
`define PERIODIC_SPHERE_OVERLAP_TEST_UNIT_MACROS_SVH

// same-cycle implication check
`define PSOT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication check
`define PSOT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/psot_pkg.sv */
// ----------------------------------------------------------------------------
// psot_pkg
// types and constants shared by the periodic sphere overlap test unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psot_pkg;

   // fixed point formats
   localparam int FRAC_BITS  = 16;
   localparam int SCALE_FRAC = 16;
   // left side of the test is scaled by 4 * 2^(2*SCALE_FRAC)
   localparam int LHS_SHIFT  = 2 + 2 * SCALE_FRAC;

   localparam int CSR_ADDR_W = 4;
   localparam int NUM_IMAGES = 27;
   localparam int NUM_GROUPS = NUM_IMAGES / 3;

   // acceptance to result strobe, in cycles
   localparam int PIPE_LATENCY = 8;

   localparam logic [30:0] BOX_RESET   = 31'(10 << FRAC_BITS);
   localparam logic [19:0] SCALE_RESET = 20'(1 << SCALE_FRAC);

   typedef enum logic [1:0] {
      REG_BOX_X = 2'd0,
      REG_BOX_Y = 2'd1,
      REG_BOX_Z = 2'd2,
      REG_SCALE = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic signed [31:0] first_x;
      logic signed [31:0] first_y;
      logic signed [31:0] first_z;
      logic        [30:0] first_diam;
      logic signed [31:0] second_x;
      logic signed [31:0] second_y;
      logic signed [31:0] second_z;
      logic        [30:0] second_diam;
   } req_type;

   typedef struct packed {
      logic [4:0] image_hits;
      logic       overlap;
   } rsp_type;

   // live configuration handed to the datapath
   typedef struct packed {
      logic [30:0] box_x;
      logic [30:0] box_y;
      logic [30:0] box_z;
      logic [39:0] scale_sq;
   } cfg_type;

   // per axis offsets of the three images, two's complement, index 0 is -box
   typedef struct packed {
      logic [2:0][33:0] ex;
      logic [2:0][33:0] ey;
      logic [2:0][33:0] ez;
      logic [31:0]      dsum;
   } ofs_type;

   // squared distances of all images and the two halves of the bound
   typedef struct packed {
      logic [NUM_IMAGES-1:0][67:0] dist_sq;
      logic [71:0]                 bound_lo;
      logic [71:0]                 bound_hi;
   } dist_type;

endpackage

/* rtl/psot_csr.sv */
// ----------------------------------------------------------------------------
// psot_csr
// apb register file: box lengths and scale factor, plus squared scale
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psot_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [psot_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready,
   output psot_pkg::cfg_type               cfg
);

   logic [30:0] box_x_ff, box_x_in;
   logic [30:0] box_y_ff, box_y_in;
   logic [30:0] box_z_ff, box_z_in;
   logic [19:0] scale_ff, scale_in;
   logic [39:0] scale_sq_ff, scale_sq_in;
   logic        wr_en;
   psot_pkg::csr_reg_type sel;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign sel    = psot_pkg::csr_reg_type'(paddr[3:2]);

   always_comb begin
      box_x_in = box_x_ff;
      box_y_in = box_y_ff;
      box_z_in = box_z_ff;
      scale_in = scale_ff;
      if (wr_en) begin
         case (sel)
            psot_pkg::REG_BOX_X: box_x_in = pwdata[30:0];
            psot_pkg::REG_BOX_Y: box_y_in = pwdata[30:0];
            psot_pkg::REG_BOX_Z: box_z_in = pwdata[30:0];
            psot_pkg::REG_SCALE: scale_in = pwdata[19:0];
            default: ;
         endcase
      end
   end

   // squared scale is registered behind the scale register, well before use
   assign scale_sq_in = scale_ff * scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_x_ff <= psot_pkg::BOX_RESET;
         box_y_ff <= psot_pkg::BOX_RESET;
         box_z_ff <= psot_pkg::BOX_RESET;
         scale_ff <= psot_pkg::SCALE_RESET;
      end else begin
         box_x_ff <= box_x_in;
         box_y_ff <= box_y_in;
         box_z_ff <= box_z_in;
         scale_ff <= scale_in;
      end
   end

   always_ff @(posedge clock) begin
      scale_sq_ff <= scale_sq_in;
   end

   always_comb begin
      case (sel)
         psot_pkg::REG_BOX_X: prdata = {1'b0, box_x_ff};
         psot_pkg::REG_BOX_Y: prdata = {1'b0, box_y_ff};
         psot_pkg::REG_BOX_Z: prdata = {1'b0, box_z_ff};
         psot_pkg::REG_SCALE: prdata = {12'b0, scale_ff};
         default:             prdata = 32'b0;
      endcase
   end

   assign cfg.box_x    = box_x_ff;
   assign cfg.box_y    = box_y_ff;
   assign cfg.box_z    = box_z_ff;
   assign cfg.scale_sq = scale_sq_ff;

endmodule

/* rtl/psot_offset.sv */
// ----------------------------------------------------------------------------
// psot_offset
// stages 1-2: centre differences and diameter sum, then image offsets
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psot_offset (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  psot_pkg::req_type req,
   input  psot_pkg::cfg_type cfg,
   output logic              out_valid,
   output psot_pkg::ofs_type ofs
);

   logic        v1_ff, v2_ff;
   logic [32:0] dx_ff, dx_in;
   logic [32:0] dy_ff, dy_in;
   logic [32:0] dz_ff, dz_in;
   logic [31:0] dsum_ff, dsum_in;
   psot_pkg::ofs_type ofs_ff, ofs_in;

   // stage 1: exact 33 bit differences
   assign dx_in   = {req.first_x[31], req.first_x} - {req.second_x[31], req.second_x};
   assign dy_in   = {req.first_y[31], req.first_y} - {req.second_y[31], req.second_y};
   assign dz_in   = {req.first_z[31], req.first_z} - {req.second_z[31], req.second_z};
   assign dsum_in = {1'b0, req.first_diam} + {1'b0, req.second_diam};

   // stage 2: shift by -box, 0, +box
   always_comb begin
      ofs_in.ex[0] = {dx_ff[32], dx_ff} - {3'b000, cfg.box_x};
      ofs_in.ex[1] = {dx_ff[32], dx_ff};
      ofs_in.ex[2] = {dx_ff[32], dx_ff} + {3'b000, cfg.box_x};
      ofs_in.ey[0] = {dy_ff[32], dy_ff} - {3'b000, cfg.box_y};
      ofs_in.ey[1] = {dy_ff[32], dy_ff};
      ofs_in.ey[2] = {dy_ff[32], dy_ff} + {3'b000, cfg.box_y};
      ofs_in.ez[0] = {dz_ff[32], dz_ff} - {3'b000, cfg.box_z};
      ofs_in.ez[1] = {dz_ff[32], dz_ff};
      ofs_in.ez[2] = {dz_ff[32], dz_ff} + {3'b000, cfg.box_z};
      ofs_in.dsum  = dsum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      dz_ff   <= dz_in;
      dsum_ff <= dsum_in;
      ofs_ff  <= ofs_in;
   end

   assign out_valid = v2_ff;
   assign ofs       = ofs_ff;

endmodule

/* rtl/psot_dist.sv */
// ----------------------------------------------------------------------------
// psot_dist
// stages 3-5: squares, pair sums and bound partial products, image distances
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psot_dist (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  psot_pkg::ofs_type  ofs,
   input  psot_pkg::cfg_type  cfg,
   output logic               out_valid,
   output psot_pkg::dist_type dst
);

   logic              v3_ff, v4_ff, v5_ff;
   logic [2:0][65:0]  sqx_ff, sqx_in;
   logic [2:0][65:0]  sqy_ff, sqy_in;
   logic [2:0][65:0]  sqz_ff, sqz_in;
   logic [63:0]       dsq_ff, dsq_in;
   logic [8:0][66:0]  sxy_ff, sxy_in;
   logic [2:0][65:0]  sz_ff, sz_in;
   logic [51:0]       pp0_ff, pp0_in;
   logic [51:0]       pp1_ff, pp1_in;
   logic [51:0]       pp2_ff, pp2_in;
   logic [51:0]       pp3_ff, pp3_in;
   psot_pkg::dist_type dst_ff, dst_in;

   // stage 3: squares of offsets, |e| < 2^33 so the square fits 66 bits
   always_comb begin
      logic signed [67:0] px;
      logic signed [67:0] py;
      logic signed [67:0] pz;
      for (int i = 0; i < 3; i++) begin
         px = $signed(ofs.ex[i]) * $signed(ofs.ex[i]);
         py = $signed(ofs.ey[i]) * $signed(ofs.ey[i]);
         pz = $signed(ofs.ez[i]) * $signed(ofs.ez[i]);
         sqx_in[i] = px[65:0];
         sqy_in[i] = py[65:0];
         sqz_in[i] = pz[65:0];
      end
   end

   assign dsq_in = ofs.dsum * ofs.dsum;

   // stage 4: x+y sums, bound as four 32x20 partial products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            sxy_in[i*3+j] = {1'b0, sqx_ff[i]} + {1'b0, sqy_ff[j]};
         end
      end
   end

   assign sz_in  = sqz_ff;
   assign pp0_in = dsq_ff[31:0]  * cfg.scale_sq[19:0];
   assign pp1_in = dsq_ff[31:0]  * cfg.scale_sq[39:20];
   assign pp2_in = dsq_ff[63:32] * cfg.scale_sq[19:0];
   assign pp3_in = dsq_ff[63:32] * cfg.scale_sq[39:20];

   // stage 5: full distances, bound folded into two halves
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
               dst_in.dist_sq[i*9+j*3+k] = {1'b0, sxy_ff[i*3+j]} + {2'b00, sz_ff[k]};
            end
         end
      end
      dst_in.bound_lo = {20'b0, pp0_ff} + {pp1_ff, 20'b0};
      dst_in.bound_hi = {20'b0, pp2_ff} + {pp3_ff, 20'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v3_ff <= in_valid;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      sqx_ff <= sqx_in;
      sqy_ff <= sqy_in;
      sqz_ff <= sqz_in;
      dsq_ff <= dsq_in;
      sxy_ff <= sxy_in;
      sz_ff  <= sz_in;
      pp0_ff <= pp0_in;
      pp1_ff <= pp1_in;
      pp2_ff <= pp2_in;
      pp3_ff <= pp3_in;
      dst_ff <= dst_in;
   end

   assign out_valid = v5_ff;
   assign dst       = dst_ff;

endmodule

/* rtl/psot_count.sv */
// ----------------------------------------------------------------------------
// psot_count
// stages 6-8: final bound, strict compares in groups of three, hit count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psot_count (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  psot_pkg::dist_type dst,
   output logic               out_valid,
   output psot_pkg::rsp_type  rsp
);

   localparam int N = psot_pkg::NUM_IMAGES;
   localparam int G = psot_pkg::NUM_GROUPS;
   localparam int SH = psot_pkg::LHS_SHIFT;

   logic                v6_ff, v7_ff, v8_ff;
   logic [103:0]        bound_ff, bound_in;
   logic [N-1:0][67:0]  dist_ff;
   logic [G-1:0][1:0]   grp_ff, grp_in;
   psot_pkg::rsp_type   rsp_ff, rsp_in;

   // stage 6: bound = dsum^2 * scale^2, exact at 104 bits
   assign bound_in = {32'b0, dst.bound_lo} + {dst.bound_hi, 32'b0};

   // stage 7: dist * 4 * 2^32 < bound, counted three images at a time
   always_comb begin
      logic [2:0] hit;
      for (int g = 0; g < G; g++) begin
         for (int k = 0; k < 3; k++) begin
            hit[k] = {2'b00, dist_ff[g*3+k], {SH{1'b0}}} < bound_ff;
         end
         grp_in[g] = {1'b0, hit[0]} + {1'b0, hit[1]} + {1'b0, hit[2]};
      end
   end

   // stage 8: total of nine group counts
   always_comb begin
      logic [4:0] cnt;
      cnt = 5'd0;
      for (int g = 0; g < G; g++) begin
         cnt = cnt + {3'b000, grp_ff[g]};
      end
      rsp_in.image_hits = cnt;
      rsp_in.overlap    = (cnt != 5'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else begin
         v6_ff <= in_valid;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      bound_ff <= bound_in;
      dist_ff  <= dst.dist_sq;
      grp_ff   <= grp_in;
      rsp_ff   <= rsp_in;
   end

   assign out_valid = v8_ff;
   assign rsp       = rsp_ff;

endmodule

/* rtl/periodic_sphere_overlap_test_unit.sv */
// ----------------------------------------------------------------------------
// periodic_sphere_overlap_test_unit
// counts the periodic images of one sphere that overlap a second sphere
// ----------------------------------------------------------------------------
// a fully pipelined unit: busy is always low, so a new sphere pair word can be
// started in every cycle, and each word's result shows on rsp_data with
// rsp_valid high for exactly one cycle, once it has passed every stage.
// the rate of one word per cycle and the pipeline latency are set by the
// eight register stages of the datapath (differences, image offsets, squares,
// pair sums and bound products, distances, bound, compares, count). results
// come out in start order and cannot be held off, so the receiver must take
// rsp_data in the cycle it is strobed. the first sphere is tried at 27 images
// (-box, 0, +box per axis); an image hits when its squared centre distance is
// strictly below ((da+db)^2/4)*scale^2, compared exactly with no rounding.
// box lengths and scale are to be written by the user over the csr apb port
// (byte addresses 0, 4, 8, 12) only while no word is in flight; the unit does
// not enforce this, and it needs no clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "periodic_sphere_overlap_test_unit_macros.svh"

module periodic_sphere_overlap_test_unit (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            start,
   output logic                            busy,
   input  psot_pkg::req_type               req_data,
   // result channel
   output logic                            rsp_valid,
   output psot_pkg::rsp_type               rsp_data,
   // configuration port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [psot_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   psot_pkg::cfg_type  cfg;
   psot_pkg::ofs_type  ofs;
   psot_pkg::dist_type dst;
   logic               req_fire;
   logic               ofs_valid;
   logic               dst_valid;

   // the pipeline never stalls, so a word is taken whenever start is high
   assign busy     = 1'b0;
   assign req_fire = start & ~busy;

   // register file, squared scale kept ready for the bound products
   psot_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // stages 1-2: differences and per axis image offsets
   psot_offset u_offset (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_fire),
      .req       (req_data),
      .cfg       (cfg),
      .out_valid (ofs_valid),
      .ofs       (ofs)
   );

   // stages 3-5: squares, distances of all 27 images, bound halves
   psot_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ofs_valid),
      .ofs       (ofs),
      .cfg       (cfg),
      .out_valid (dst_valid),
      .dst       (dst)
   );

   // stages 6-8: compares against the bound and hit count
   psot_count u_count (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dst_valid),
      .dst       (dst),
      .out_valid (rsp_valid),
      .rsp       (rsp_data)
   );

   // every started word yields a strobe after the full pipeline depth
   `PSOT_ASSERT_SAME(a_start_to_rsp, req_fire, ##(psot_pkg::PIPE_LATENCY) rsp_valid, "result strobe missing after start")
   // no strobe without a word started that many cycles before
   `PSOT_ASSERT_SAME(a_rsp_from_start, rsp_valid, $past(req_fire, psot_pkg::PIPE_LATENCY), "result strobe without a started word")
   // count stays within the number of images and agrees with the flag
   `PSOT_ASSERT_SAME(a_rsp_consistent, rsp_valid, (rsp_data.image_hits <= 5'd27) && (rsp_data.overlap == (rsp_data.image_hits != 5'd0)), "hit count and overlap flag disagree")
   // a strobe lasts one cycle unless another word was started right behind
   `PSOT_ASSERT_NEXT(a_rsp_single, rsp_valid && !$past(req_fire, psot_pkg::PIPE_LATENCY - 1), !rsp_valid, "result strobe held too long")

endmodule
